// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cesu_pkg.sv =====
// ----------------------------------------------------------------------------
// cesu_pkg
// shared types, constants and byte classifiers for the cesu-8 recombiner
// ----------------------------------------------------------------------------
package cesu_pkg;

    localparam int BURST_MAX = 6;
    localparam int CNT_W     = 3;

    localparam logic [7:0]  BYTE_LEAD    = 8'hED;
    localparam logic [7:0]  UTF8_LEAD4   = 8'hF0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [3:0]  NIB_HIGH_SUR = 4'hA;
    localparam logic [3:0]  NIB_LOW_SUR  = 4'hB;
    localparam logic [1:0]  TOP_CONT     = 2'b10;
    localparam logic [10:0] PLANE_OFFSET = 11'h040;

    typedef enum logic [2:0] {
        HOLD_NONE,
        HOLD_ED,
        HOLD_HI,
        HOLD_HI_C,
        HOLD_HI_C_ED,
        HOLD_LO
    } hold_state_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] data;
        logic [CNT_W-1:0]          count;
    } burst_t;

    function automatic logic is_high_sur(input logic [7:0] b);
        return b[7:4] == NIB_HIGH_SUR;
    endfunction

    function automatic logic is_low_sur(input logic [7:0] b);
        return b[7:4] == NIB_LOW_SUR;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == TOP_CONT;
    endfunction

endpackage

// ===== rtl/cesu_core.sv =====
// ----------------------------------------------------------------------------
// cesu_core
// held-prefix state machine; turns one input byte into a burst of output bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cesu_core
    import cesu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    output burst_t     burst
);

    hold_state_t state_reg, state_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  c1_reg, c1_next;
    logic [7:0]  lo_reg, lo_next;

    logic [10:0] cp_upper;
    logic [20:0] cp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HOLD_NONE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        c1_reg <= c1_next;
        lo_reg <= lo_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        hi_next    = hi_reg;
        c1_next    = c1_reg;
        lo_next    = lo_reg;
        if (in_fire) begin
            case (state_reg)
                HOLD_NONE: begin
                    state_next = (in_byte == BYTE_LEAD) ? HOLD_ED : HOLD_NONE;
                end
                HOLD_ED: begin
                    if (is_high_sur(in_byte)) begin
                        state_next = HOLD_HI;
                        hi_next    = in_byte;
                    end else begin
                        state_next = (in_byte == BYTE_LEAD) ? HOLD_ED : HOLD_NONE;
                    end
                end
                HOLD_HI: begin
                    if (is_cont(in_byte)) begin
                        state_next = HOLD_HI_C;
                        c1_next    = in_byte;
                    end else begin
                        state_next = (in_byte == BYTE_LEAD) ? HOLD_ED : HOLD_NONE;
                    end
                end
                HOLD_HI_C: begin
                    state_next = (in_byte == BYTE_LEAD) ? HOLD_HI_C_ED : HOLD_NONE;
                end
                HOLD_HI_C_ED: begin
                    if (is_low_sur(in_byte)) begin
                        state_next = HOLD_LO;
                        lo_next    = in_byte;
                    end else if (is_high_sur(in_byte)) begin
                        state_next = HOLD_HI;
                        hi_next    = in_byte;
                    end else begin
                        state_next = (in_byte == BYTE_LEAD) ? HOLD_ED : HOLD_NONE;
                    end
                end
                HOLD_LO: begin
                    state_next = (in_byte == BYTE_LEAD && !is_cont(in_byte)) ?
                                 HOLD_ED : HOLD_NONE;
                end
                default: begin
                    state_next = HOLD_NONE;
                end
            endcase
        end
    end

    // supplementary code point from the held pair
    assign cp_upper = {1'b0, hi_reg[3:0], c1_reg[5:0]} + PLANE_OFFSET;
    assign cp       = {cp_upper, lo_reg[3:0], in_byte[5:0]};

    // outputs
    always_comb begin
        burst = '0;
        case (state_reg)
            HOLD_NONE: begin
                if (in_byte != BYTE_LEAD) begin
                    burst.data[0] = in_byte;
                    burst.count   = CNT_W'(1);
                end
            end
            HOLD_ED: begin
                if (!is_high_sur(in_byte)) begin
                    burst.data[0] = BYTE_LEAD;
                    burst.data[1] = in_byte;
                    burst.count   = (in_byte == BYTE_LEAD) ? CNT_W'(1) : CNT_W'(2);
                end
            end
            HOLD_HI: begin
                if (!is_cont(in_byte)) begin
                    burst.data[0] = BYTE_LEAD;
                    burst.data[1] = hi_reg;
                    burst.data[2] = in_byte;
                    burst.count   = (in_byte == BYTE_LEAD) ? CNT_W'(2) : CNT_W'(3);
                end
            end
            HOLD_HI_C: begin
                if (in_byte != BYTE_LEAD) begin
                    burst.data[0] = BYTE_LEAD;
                    burst.data[1] = hi_reg;
                    burst.data[2] = c1_reg;
                    burst.data[3] = in_byte;
                    burst.count   = CNT_W'(4);
                end
            end
            HOLD_HI_C_ED: begin
                if (!is_low_sur(in_byte)) begin
                    burst.data[0] = BYTE_LEAD;
                    burst.data[1] = hi_reg;
                    burst.data[2] = c1_reg;
                    burst.data[3] = BYTE_LEAD;
                    burst.data[4] = in_byte;
                    if (is_high_sur(in_byte)) begin
                        burst.count = CNT_W'(3);
                    end else if (in_byte == BYTE_LEAD) begin
                        burst.count = CNT_W'(4);
                    end else begin
                        burst.count = CNT_W'(5);
                    end
                end
            end
            HOLD_LO: begin
                if (is_cont(in_byte)) begin
                    burst.data[0] = UTF8_LEAD4 | {5'd0, cp[20:18]};
                    burst.data[1] = UTF8_CONT | {2'd0, cp[17:12]};
                    burst.data[2] = UTF8_CONT | {2'd0, cp[11:6]};
                    burst.data[3] = UTF8_CONT | {2'd0, cp[5:0]};
                    burst.count   = CNT_W'(4);
                end else begin
                    burst.data[0] = BYTE_LEAD;
                    burst.data[1] = hi_reg;
                    burst.data[2] = c1_reg;
                    burst.data[3] = BYTE_LEAD;
                    burst.data[4] = lo_reg;
                    burst.data[5] = in_byte;
                    burst.count   = (in_byte == BYTE_LEAD) ? CNT_W'(5) : CNT_W'(6);
                end
            end
            default: begin
                burst = '0;
            end
        endcase
    end

    `ASSERT_CLK(a_pair_gives_four, aclk, aresetn,
        (in_fire && state_reg == HOLD_LO && is_cont(in_byte)) |-> (burst.count == CNT_W'(4)),
        "complete surrogate pair did not give four bytes")
    `ASSERT_CLK(a_pair_clears_hold, aclk, aresetn,
        (in_fire && state_reg == HOLD_LO && is_cont(in_byte)) |=> (state_reg == HOLD_NONE),
        "hold not cleared after a complete pair")

endmodule

// ===== rtl/cesu_burst.sv =====
// ----------------------------------------------------------------------------
// cesu_burst
// result register; holds a burst, sent while m_tready high, one word per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cesu_burst
    import cesu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst,
    output logic       load_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte[7:0]
    output logic       m_tlast      // run_last
);

    logic [BURST_MAX-1:0][7:0] buf_reg, buf_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pop;

    assign pop        = m_tvalid && m_tready;
    assign m_tvalid   = cnt_reg != '0;
    assign m_tlast    = cnt_reg == CNT_W'(1);
    assign m_tdata    = buf_reg[0];
    assign load_ready = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = burst.data;
            cnt_next = burst.count;
        end else if (pop) begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn,
        cnt_reg <= CNT_W'(BURST_MAX),
        "burst count above six")
    `ASSERT_CLK(a_pop_steps, aclk, aresetn,
        (pop && !load) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)),
        "burst count did not step down on a taken word")

endmodule

// ===== rtl/cesu8_to_utf8_recombiner_top.sv =====
// ----------------------------------------------------------------------------
// cesu8_to_utf8_recombiner_top
// byte stream recombiner: cesu-8 surrogate pairs become 4-byte utf-8
// ----------------------------------------------------------------------------
// input channel s_*: one raw byte per word in s_tdata[7:0]
// output channel m_*: one utf-8 byte per word in m_tdata[7:0]; m_tlast marks
// the last byte released by one input byte
// most bytes are registered and reach the output word in the cycle after input
// a byte that extends a partial surrogate pair is held and releases nothing
// a byte that breaks or completes a pair releases a burst of up to six words
// output runs at one word per cycle while m_tready is high; s_tready is
// high while the result register is empty or is giving up its last word
// this cycle, so single-byte traffic flows at one word per cycle
// when m_tready is low the result register holds its words and s_tready
// stays low until the last of them is taken
// reset (aresetn low, synchronous) empties the result register and drops
// any held prefix; held bytes are only released by later input bytes
// ----------------------------------------------------------------------------
module cesu8_to_utf8_recombiner_top
    import cesu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte[7:0]
    output logic       m_tlast      // run_last
);

    logic   s_fire;
    burst_t burst;

    assign s_fire = s_tvalid && s_tready;

    cesu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .burst   (burst)
    );

    cesu_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_fire),
        .burst      (burst),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
